// ----- rtl/lzc_pkg.sv -----
// Shared types, constants and the LoG kernel for the zero-crossing edge detector.
package lzc_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int FLT_W = 17;
	localparam int POS_OUT_W = 10;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int RESET_WIDTH = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int KSIZE = 9;
	localparam int PIX_ROWS = KSIZE - 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_e;

	// Channel 0 is red, 1 green, 2 blue.
	typedef logic [2:0][PIX_W-1:0] pix_t;
	typedef pix_t [PIX_ROWS-1:0] pcol_t;
	typedef pix_t [KSIZE-1:0] pix9_t;

	typedef logic signed [FLT_W-1:0] flt_t;
	typedef flt_t [2:0] flt3_t;
	typedef flt3_t [1:0] fcol_t;
	typedef flt3_t [2:0] flt3col_t;

	// Item control at the default frame limits.
	typedef struct packed {
		logic        f_act;
		logic [11:0] frow;
		logic [9:0]  fcol;
		logic        o_act;
		logic [11:0] orow;
		logic [9:0]  ocol;
		logic        last;
	} lzc_item_t;

	localparam logic signed [7:0] LOG_KERNEL [KSIZE*KSIZE] = '{
		8'sd0, 8'sd1, 8'sd1,   8'sd2,   8'sd2,   8'sd2, 8'sd1, 8'sd1, 8'sd0,
		8'sd1, 8'sd2, 8'sd4,   8'sd5,   8'sd5,   8'sd5, 8'sd4, 8'sd2, 8'sd1,
		8'sd1, 8'sd4, 8'sd5,   8'sd3,   8'sd0,   8'sd3, 8'sd5, 8'sd4, 8'sd1,
		8'sd2, 8'sd5, 8'sd3, -8'sd12, -8'sd24, -8'sd12, 8'sd3, 8'sd5, 8'sd2,
		8'sd2, 8'sd5, 8'sd0, -8'sd24, -8'sd50, -8'sd24, 8'sd0, 8'sd5, 8'sd2,
		8'sd2, 8'sd5, 8'sd3, -8'sd12, -8'sd24, -8'sd12, 8'sd3, 8'sd5, 8'sd2,
		8'sd1, 8'sd4, 8'sd5,   8'sd3,   8'sd0,   8'sd3, 8'sd5, 8'sd4, 8'sd1,
		8'sd1, 8'sd2, 8'sd4,   8'sd5,   8'sd5,   8'sd5, 8'sd4, 8'sd2, 8'sd1,
		8'sd0, 8'sd1, 8'sd1,   8'sd2,   8'sd2,   8'sd2, 8'sd1, 8'sd1, 8'sd0
	};

endpackage

// ----- rtl/lzc_if.sv -----
// Pixel input and edge output channel interfaces.
interface lzc_pix_if import lzc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	logic             flush;

	modport source(output valid, red, green, blue, flush, input ready);
	modport sink(input valid, red, green, blue, flush, output ready);
endinterface

interface lzc_edge_if import lzc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 edge_res;
	logic [POS_OUT_W-1:0] column;
	logic [POS_OUT_W-1:0] row;
	logic                 frame_end;

	modport source(output valid, edge_res, column, row, frame_end, input ready);
	modport sink(input valid, edge_res, column, row, frame_end, output ready);
endinterface

// ----- rtl/lzc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lzc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/lzc_ctrl.sv -----
// Frame size registers and the raster position counters of the input, filter and output.
module lzc_ctrl import lzc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter type item_t = lzc_item_t
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [CFG_IDX_W-1:0]              cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data,
	input  logic                              in_valid,
	input  logic                              in_flush,
	input  logic                              adv,
	output logic                              proc,
	output item_t                             item,
	output logic [$clog2(MAX_WIDTH)-1:0]      col,
	output logic [$clog2(MAX_WIDTH+1)-1:0]    width,
	output logic [$clog2(MAX_HEIGHT+1)-1:0]   height
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT) + 2;
	localparam int KW = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 3;
	localparam int XW = (WW > CFG_W) ? WW : CFG_W;
	localparam int XH = (HW > CFG_W) ? HW : CFG_W;

	logic [CFG_W-1:0] w_cfg_q, h_cfg_q;
	logic [CW-1:0]    ic_q, fc_q, oc_q;
	logic [RW-1:0]    ir_q, fr_q, or_q;
	logic [KW-1:0]    k_q;
	logic             f_act_q, o_act_q;

	logic [XW-1:0] w_ext;
	logic [XH-1:0] h_ext;
	logic [KW-1:0] lag_f, lag_o;
	logic          pix_phase, f_now, o_now, last;
	logic [CW-1:0] fc_c, oc_c;
	logic [RW-1:0] fr_c, or_c;

	// Sizes saturate to the supported range.
	always_comb begin
		w_ext = XW'(w_cfg_q);
		h_ext = XH'(h_cfg_q);
		if (w_ext == '0) begin
			width = WW'(1);
		end else if (w_ext > XW'(MAX_WIDTH)) begin
			width = WW'(MAX_WIDTH);
		end else begin
			width = WW'(w_ext);
		end
		if (h_ext == '0) begin
			height = HW'(1);
		end else if (h_ext > XH'(MAX_HEIGHT)) begin
			height = HW'(MAX_HEIGHT);
		end else begin
			height = HW'(h_ext);
		end
	end

	// The filter runs 4W+4 words behind the input and the flags 5W+5 words behind.
	assign lag_f = (KW'(width) << 2) + KW'(4);
	assign lag_o = (KW'(width) << 2) + KW'(width) + KW'(5);

	assign pix_phase = ir_q < RW'(height);
	assign proc = in_valid && adv && !(pix_phase && in_flush);

	assign f_now = f_act_q || (k_q == lag_f);
	assign fr_c = f_act_q ? fr_q : '0;
	assign fc_c = f_act_q ? fc_q : '0;
	assign o_now = o_act_q || (k_q == lag_o);
	assign or_c = o_act_q ? or_q : '0;
	assign oc_c = o_act_q ? oc_q : '0;
	assign last = o_now && (or_c == RW'(height) - RW'(1)) && (WW'(oc_c) + WW'(1) == width);

	assign col = ic_q;
	always_comb begin
		item = '0;
		item.f_act = f_now;
		item.frow = fr_c;
		item.fcol = fc_c;
		item.o_act = o_now;
		item.orow = or_c;
		item.ocol = oc_c;
		item.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cfg_q <= CFG_W'(RESET_WIDTH);
			h_cfg_q <= CFG_W'(RESET_HEIGHT);
			ic_q <= '0;
			ir_q <= '0;
			k_q <= '0;
			f_act_q <= 1'b0;
			fr_q <= '0;
			fc_q <= '0;
			o_act_q <= 1'b0;
			or_q <= '0;
			oc_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_WIDTH: begin
					w_cfg_q <= cfg_data;
				end
				REG_HEIGHT: begin
					h_cfg_q <= cfg_data;
				end
			endcase
			ic_q <= '0;
			ir_q <= '0;
			k_q <= '0;
			f_act_q <= 1'b0;
			o_act_q <= 1'b0;
		end else if (proc) begin
			if (last) begin
				ic_q <= '0;
				ir_q <= '0;
				k_q <= '0;
				f_act_q <= 1'b0;
				o_act_q <= 1'b0;
			end else begin
				k_q <= k_q + KW'(1);
				if (WW'(ic_q) + WW'(1) == width) begin
					ic_q <= '0;
					ir_q <= ir_q + RW'(1);
				end else begin
					ic_q <= ic_q + CW'(1);
				end
				f_act_q <= f_now;
				if (f_now) begin
					if (WW'(fc_c) + WW'(1) == width) begin
						fc_q <= '0;
						fr_q <= fr_c + RW'(1);
					end else begin
						fc_q <= fc_c + CW'(1);
						fr_q <= fr_c;
					end
				end
				o_act_q <= o_now;
				if (o_now) begin
					if (WW'(oc_c) + WW'(1) == width) begin
						oc_q <= '0;
						or_q <= or_c + RW'(1);
					end else begin
						oc_q <= oc_c + CW'(1);
						or_q <= or_c;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/lzc_conv.sv -----
// Pixel line store, 9x9 window and the pipelined LoG convolution.
module lzc_conv import lzc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter type item_t = lzc_item_t
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
	input  logic                            in_valid,
	input  item_t                           in_item,
	input  logic [$clog2(MAX_WIDTH)-1:0]    in_col,
	input  pix_t                            in_pix,
	output logic                            out_valid,
	output item_t                           out_item,
	output flt3_t                           out_flt
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT) + 2;

	logic          valid_c1, valid_c2, valid_c3;
	item_t         item_c1, item_c2, item_c3;
	logic [CW-1:0] col_c1;
	pix_t          pix_c1;
	logic          fwd_c1;
	pcol_t         fwd_data_c1;
	pcol_t         ram_rdata, stored_c1, wdata_c1;
	pix9_t         newcol_c1;
	pix9_t         pwin_q [KSIZE];
	logic          colok [KSIZE];
	logic          rowok [KSIZE];
	flt_t          rows_c2 [3][KSIZE];
	flt_t          rows_c3 [3][KSIZE];
	flt3_t         sum_c3;

	// A column read in the cycle its previous update is written takes the new data directly.
	always_comb begin
		stored_c1 = fwd_c1 ? fwd_data_c1 : ram_rdata;
		for (int j = 0; j < PIX_ROWS; j++) begin
			newcol_c1[j] = stored_c1[j];
		end
		newcol_c1[KSIZE-1] = pix_c1;
		for (int j = 0; j < PIX_ROWS; j++) begin
			wdata_c1[j] = newcol_c1[j+1];
		end
	end

	lzc_ram #(
		.WIDTH($bits(pcol_t)),
		.DEPTH(MAX_WIDTH)
	) u_pix_ram (
		.clk(clk),
		.we(adv && valid_c1),
		.waddr(col_c1),
		.wdata(wdata_c1),
		.re(adv && in_valid),
		.raddr(in_col),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_c1 <= 1'b0;
			valid_c2 <= 1'b0;
			valid_c3 <= 1'b0;
			out_valid <= 1'b0;
			fwd_c1 <= 1'b0;
		end else if (adv) begin
			valid_c1 <= in_valid;
			valid_c2 <= valid_c1;
			valid_c3 <= valid_c2;
			out_valid <= valid_c3;
			fwd_c1 <= valid_c1 && in_valid && (col_c1 == in_col);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_c1 <= in_item;
			col_c1 <= in_col;
			pix_c1 <= in_pix;
			fwd_data_c1 <= wdata_c1;
			item_c2 <= item_c1;
			item_c3 <= item_c2;
			rows_c3 <= rows_c2;
			out_item <= item_c3;
			out_flt <= sum_c3;
			if (valid_c1) begin
				pwin_q[0] <= newcol_c1;
				for (int d = 1; d < KSIZE; d++) begin
					pwin_q[d] <= pwin_q[d-1];
				end
			end
		end
	end

	// Window column d holds image column fcol+4-d; row j holds image row frow+j-4.
	always_comb begin
		for (int d = 0; d < KSIZE; d++) begin
			if (d < 4) begin
				colok[d] = (WW+1)'(item_c2.fcol) + (WW+1)'(4 - d) < (WW+1)'(width);
			end else if (d > 4) begin
				colok[d] = (WW+1)'(item_c2.fcol) >= (WW+1)'(d - 4);
			end else begin
				colok[d] = 1'b1;
			end
		end
		for (int j = 0; j < KSIZE; j++) begin
			if (j < 4) begin
				rowok[j] = (RW+1)'(item_c2.frow) >= (RW+1)'(4 - j);
			end else if (j > 4) begin
				rowok[j] = (RW+1)'(item_c2.frow) + (RW+1)'(j - 4) < (RW+1)'(height);
			end else begin
				rowok[j] = (RW+1)'(item_c2.frow) < (RW+1)'(height);
			end
		end
	end

	always_comb begin
		logic signed [FLT_W-1:0] acc;
		for (int ch = 0; ch < 3; ch++) begin
			for (int j = 0; j < KSIZE; j++) begin
				acc = '0;
				for (int d = 0; d < KSIZE; d++) begin
					if (colok[d] && rowok[j]) begin
						acc = acc + $signed({{(FLT_W-PIX_W){1'b0}}, pwin_q[d][j][ch]})
							* FLT_W'(LOG_KERNEL[j*KSIZE + KSIZE - 1 - d]);
					end
				end
				rows_c2[ch][j] = acc;
			end
		end
	end

	always_comb begin
		logic signed [FLT_W-1:0] tot;
		for (int ch = 0; ch < 3; ch++) begin
			tot = '0;
			for (int j = 0; j < KSIZE; j++) begin
				tot = tot + rows_c3[ch][j];
			end
			sum_c3[ch] = tot;
		end
	end

endmodule

// ----- rtl/lzc_zc.sv -----
// Filtered line store, 3x3 window and the zero-crossing test.
module lzc_zc import lzc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter type item_t = lzc_item_t
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
	input  logic                            in_valid,
	input  item_t                           in_item,
	input  flt3_t                           in_flt,
	output logic                            res_valid,
	output logic                            res_edge,
	output item_t                           res_item
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT) + 2;

	logic     take_z0;
	logic     valid_z1, valid_z2;
	item_t    item_z1, item_z2;
	flt3_t    flt_z1;
	logic     fwd_z1;
	fcol_t    fwd_data_z1, ram_rdata, stored_z1, wdata_z1;
	flt3col_t newcol_z1;
	flt3col_t fwin_q [3];
	logic     colok [3];
	logic     rowok [3];

	// Only items with a filter position enter the filtered rows.
	assign take_z0 = in_valid && in_item.f_act;

	always_comb begin
		stored_z1 = fwd_z1 ? fwd_data_z1 : ram_rdata;
		newcol_z1[0] = stored_z1[0];
		newcol_z1[1] = stored_z1[1];
		newcol_z1[2] = flt_z1;
		wdata_z1[0] = newcol_z1[1];
		wdata_z1[1] = newcol_z1[2];
	end

	lzc_ram #(
		.WIDTH($bits(fcol_t)),
		.DEPTH(MAX_WIDTH)
	) u_flt_ram (
		.clk(clk),
		.we(adv && valid_z1),
		.waddr(item_z1.fcol),
		.wdata(wdata_z1),
		.re(adv && take_z0),
		.raddr(in_item.fcol),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_z1 <= 1'b0;
			valid_z2 <= 1'b0;
			fwd_z1 <= 1'b0;
		end else if (adv) begin
			valid_z1 <= take_z0;
			valid_z2 <= valid_z1;
			fwd_z1 <= valid_z1 && take_z0 && (item_z1.fcol == in_item.fcol);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_z1 <= in_item;
			flt_z1 <= in_flt;
			fwd_data_z1 <= wdata_z1;
			item_z2 <= item_z1;
			if (valid_z1) begin
				fwin_q[0] <= newcol_z1;
				fwin_q[1] <= fwin_q[0];
				fwin_q[2] <= fwin_q[1];
			end
		end
	end

	// Window column 0 is the right neighbour, row 0 the row above.
	always_comb begin
		colok[0] = (WW+1)'(item_z2.ocol) + (WW+1)'(1) < (WW+1)'(width);
		colok[1] = 1'b1;
		colok[2] = item_z2.ocol != '0;
		rowok[0] = item_z2.orow != '0;
		rowok[1] = 1'b1;
		rowok[2] = (RW+1)'(item_z2.orow) + (RW+1)'(1) < (RW+1)'(height);
	end

	always_comb begin
		logic signed [FLT_W-1:0] a, b;
		logic [FLT_W-1:0] ma, mb;
		res_edge = 1'b0;
		for (int d = 0; d < 3; d++) begin
			for (int j = 0; j < 3; j++) begin
				for (int ch = 0; ch < 3; ch++) begin
					a = $signed(fwin_q[1][1][ch]);
					b = $signed(fwin_q[d][j][ch]);
					ma = a[FLT_W-1] ? FLT_W'(-a) : FLT_W'(a);
					mb = b[FLT_W-1] ? FLT_W'(-b) : FLT_W'(b);
					if (!(d == 1 && j == 1) && colok[d] && rowok[j]
						&& ((a < 0 && b > 0) || (a > 0 && b < 0)) && (ma <= mb)) begin
						res_edge = 1'b1;
					end
				end
			end
		end
	end

	assign res_valid = valid_z2 && item_z2.o_act;
	assign res_item = item_z2;

endmodule

// ----- rtl/log_zero_crossing_edge_detect_top.sv -----
// Top level of the LoG zero-crossing edge detector.
//
//   port      dir  role
//   pixels    in   raster RGB words, flush words drain the frame tail
//   edges     out  one edge flag per pixel, raster order
//   cfg_*     in   frame width and height writes
//
// One word is accepted per cycle while the pipeline is not held; each line store is a RAM
// with one read and one write port, read, updated and written back one column per word.
// A flag passes c1, c2, c3, the conv output, z1, z2 and the output register after the word
// that releases it is accepted; that word lies 5W+5 positions after the flagged pixel.
// Reset clears all control state; the line stores need no clearing pass.
// When the output register holds an unread flag and edges.ready is low, the whole pipeline
// holds and pixels.ready drops.
module log_zero_crossing_edge_detect_top import lzc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lzc_pix_if.sink              pixels,
	lzc_edge_if.source           edges,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT) + 2;

	typedef struct packed {
		logic          f_act;
		logic [RW-1:0] frow;
		logic [CW-1:0] fcol;
		logic          o_act;
		logic [RW-1:0] orow;
		logic [CW-1:0] ocol;
		logic          last;
	} item_t;

	logic          adv, proc;
	item_t         item, conv_item, res_item;
	logic [CW-1:0] col;
	logic [WW-1:0] width;
	logic [HW-1:0] height;
	pix_t          pix;
	logic          conv_valid, res_valid, res_edge;
	flt3_t         conv_flt;

	logic                 out_valid_q;
	logic                 edge_q;
	logic [POS_OUT_W-1:0] col_q, row_q;
	logic                 last_q;

	assign adv = !out_valid_q || edges.ready;
	assign pixels.ready = adv;

	always_comb begin
		pix[0] = pixels.red;
		pix[1] = pixels.green;
		pix[2] = pixels.blue;
	end

	lzc_ctrl #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.item_t(item_t)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(pixels.valid),
		.in_flush(pixels.flush),
		.adv(adv),
		.proc(proc),
		.item(item),
		.col(col),
		.width(width),
		.height(height)
	);

	lzc_conv #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.item_t(item_t)
	) u_conv (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.width(width),
		.height(height),
		.in_valid(proc),
		.in_item(item),
		.in_col(col),
		.in_pix(pix),
		.out_valid(conv_valid),
		.out_item(conv_item),
		.out_flt(conv_flt)
	);

	lzc_zc #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.item_t(item_t)
	) u_zc (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.width(width),
		.height(height),
		.in_valid(conv_valid),
		.in_item(conv_item),
		.in_flt(conv_flt),
		.res_valid(res_valid),
		.res_edge(res_edge),
		.res_item(res_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			edge_q <= res_edge;
			col_q <= POS_OUT_W'(res_item.ocol);
			row_q <= POS_OUT_W'(res_item.orow);
			last_q <= res_item.last;
		end
	end

	assign edges.valid = out_valid_q;
	assign edges.edge_res = edge_q;
	assign edges.column = col_q;
	assign edges.row = row_q;
	assign edges.frame_end = last_q;

endmodule

// ----- bench/edge_checker.sv -----
// Checker for the edge detector: watches the channels, predicts each flag and compares.
module edge_checker import lzc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	lzc_pix_if                   pixels,
	lzc_edge_if                  edges,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   flags_pending,
	output int                   mismatch_count
);

	typedef struct {
		bit       is_edge;
		bit [9:0] col;
		bit [9:0] row;
		bit       last;
	} edge_flag_t;

	edge_flag_t flag_queue[$];
	bit [7:0]   pix_ring[16][1024][3];
	int         log_ring[4][1024][3];
	bit [10:0]  width_reg;
	bit [10:0]  height_reg;
	int         next_col;
	int         next_row;

	assign flags_pending = flag_queue.size();

	function automatic int clamp_dim(bit [10:0] v);
		if (v == 0)
			return 1;
		if (v > 1024)
			return 1024;
		return int'(v);
	endfunction

	function automatic void compute_log(int r, int c, int w, int h);
		int sum[3];
		int rr;
		int cc;
		sum = '{0, 0, 0};
		for (int j = 0; j < KSIZE; j++) begin
			rr = r + j - 4;
			if (rr < 0 || rr >= h)
				continue;
			for (int i = 0; i < KSIZE; i++) begin
				cc = c + i - 4;
				if (cc < 0 || cc >= w)
					continue;
				for (int ch = 0; ch < 3; ch++)
					sum[ch] += int'(pix_ring[rr % 16][cc][ch]) * int'(LOG_KERNEL[j * KSIZE + i]);
			end
		end
		for (int ch = 0; ch < 3; ch++)
			log_ring[r % 4][c][ch] = sum[ch];
	endfunction

	function automatic bit is_crossing(int r, int c, int w, int h);
		int a;
		int b;
		int rr;
		int cc;
		for (int dr = -1; dr <= 1; dr++) begin
			rr = r + dr;
			if (rr < 0 || rr >= h)
				continue;
			for (int dc = -1; dc <= 1; dc++) begin
				cc = c + dc;
				if (cc < 0 || cc >= w || (dr == 0 && dc == 0))
					continue;
				for (int ch = 0; ch < 3; ch++) begin
					a = log_ring[r % 4][c][ch];
					b = log_ring[rr % 4][cc][ch];
					if (((a < 0 && b > 0) || (a > 0 && b < 0)) &&
							((a < 0 ? -a : a) <= (b < 0 ? -b : b)))
						return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// Skips a flush word inside the frame, else advances by one word and queues the flag released.
	function automatic void accept_word(bit [7:0] red, bit [7:0] green, bit [7:0] blue,
			bit flush);
		int w;
		int h;
		int n;
		int k;
		int q;
		edge_flag_t flag;
		bit last;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		n = w * h;
		k = next_row * w + next_col;
		last = 1'b0;
		if (k < n) begin
			if (flush)
				return;
			pix_ring[next_row % 16][next_col] = '{red, green, blue};
		end
		q = k - (4 * w + 4);
		if (q >= 0 && q < n)
			compute_log(q / w, q % w, w, h);
		q = k - (5 * w + 5);
		if (q >= 0 && q < n) begin
			last = (q == n - 1);
			flag.is_edge = is_crossing(q / w, q % w, w, h);
			flag.col = 10'(q % w);
			flag.row = 10'(q / w);
			flag.last = last;
			flag_queue.push_back(flag);
		end
		if (last) begin
			next_col = 0;
			next_row = 0;
		end else begin
			next_col++;
			if (next_col >= w) begin
				next_col = 0;
				next_row++;
			end
		end
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	initial mismatch_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = 11'(RESET_WIDTH);
			height_reg = 11'(RESET_HEIGHT);
			next_col = 0;
			next_row = 0;
			flag_queue.delete();
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
				next_col = 0;
				next_row = 0;
			end
			if (pixels.valid && pixels.ready)
				accept_word(pixels.red, pixels.green, pixels.blue, pixels.flush);
			if (edges.valid && edges.ready) begin
				if (flag_queue.size() == 0) begin
					report($sformatf("unexpected flag at row %0d column %0d",
						edges.row, edges.column));
				end else begin
					edge_flag_t exp_flag;
					exp_flag = flag_queue.pop_front();
					if (edges.edge_res !== exp_flag.is_edge || edges.column !== exp_flag.col ||
							edges.row !== exp_flag.row || edges.frame_end !== exp_flag.last)
						report($sformatf("got edge %b r%0d c%0d end %b, want %b r%0d c%0d end %b",
							edges.edge_res, edges.row, edges.column, edges.frame_end,
							exp_flag.is_edge, exp_flag.row, exp_flag.col, exp_flag.last));
				end
			end
		end
	end

endmodule

// ----- bench/testbench.sv -----
// Top of the edge detector testbench: clock, reset, stimulus and the verdict.
module testbench;
	import lzc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   flags_pending;
	int                   mismatch_count;
	bit                   calm;
	int                   hold_request;
	int                   hold_left;
	int                   words_sent;
	bit                   held;

	lzc_pix_if  pixels();
	lzc_edge_if edges();

	log_zero_crossing_edge_detect_top u_top (
		.clk(clk), .arst_n(arst_n), .pixels(pixels), .edges(edges),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	edge_checker u_checker (
		.clk(clk), .arst_n(arst_n), .pixels(pixels), .edges(edges),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.flags_pending(flags_pending), .mismatch_count(mismatch_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off when requested.
	initial begin
		edges.ready = 1'b0;
		hold_left = 0;
	end
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			edges.ready <= 1'b0;
		end else begin
			edges.ready <= calm || ($urandom_range(99) >= 17);
		end
	end

	task automatic send_word(bit [7:0] red, bit [7:0] green, bit [7:0] blue, bit flush);
		while (!calm && $urandom_range(99) < 17) begin
			pixels.valid <= 1'b0;
			@(posedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.red <= red;
		pixels.green <= green;
		pixels.blue <= blue;
		pixels.flush <= flush;
		do
			@(posedge clk);
		while (!pixels.ready);
		words_sent++;
	endtask

	task automatic wait_idle();
		pixels.valid <= 1'b0;
		while (flags_pending != 0)
			@(posedge clk);
		repeat (30)
			@(posedge clk);
	endtask

	task automatic write_size(int w, int h);
		cfg_write <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit [7:0] pick_level(int style);
		case (style)
			0: return 8'($urandom_range(255));
			1: return $urandom_range(1) ? 8'hFF : 8'h00;
			default: return $urandom_range(3) == 0 ? 8'hFF : 8'($urandom_range(40));
		endcase
	endfunction

	// One whole frame: pixels with occasional stray flush words, then the drain.
	task automatic run_frame(int w, int h, int style, int noise);
		int ew;
		int eh;
		ew = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
		eh = (h == 0) ? 1 : (h > 1024 ? 1024 : h);
		write_size(w, h);
		for (int k = 0; k < ew * eh; k++) begin
			if ($urandom_range(99) < noise)
				send_word(pick_level(0), pick_level(0), pick_level(0), 1'b1);
			if (style == 3)
				send_word(((k / ew + k % ew) % 2) ? 8'hFF : 8'h00, 8'h00,
					((k / ew) % 2) ? 8'h00 : 8'hFF, 1'b0);
			else
				send_word(pick_level(style), pick_level(style), pick_level(style), 1'b0);
		end
		// Pixel words during the drain only advance it, like flush words.
		for (int k = 0; k < 5 * ew + 5; k++)
			send_word(pick_level(0), pick_level(0), pick_level(0),
				$urandom_range(99) >= 20);
		wait_idle();
	endtask

	// The start of an oversized frame, abandoned by the next size write.
	task automatic run_partial(int w, int h, int count);
		write_size(w, h);
		for (int k = 0; k < count; k++)
			send_word(pick_level(0), pick_level(0), pick_level(0), 1'b0);
		wait_idle();
	endtask

	initial begin
		int w;
		int h;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		pixels.valid = 1'b0;
		pixels.red = '0;
		pixels.green = '0;
		pixels.blue = '0;
		pixels.flush = 1'b0;
		calm = 1'b0;
		hold_request = 0;
		words_sent = 0;
		held = 1'b0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_frame(3, 3, 3, 30);
		run_frame(0, 0, 1, 0);
		run_partial(2047, 2047, 40);
		run_frame(5, 4, 1, 0);

		while (words_sent < 780) begin
			if (!held && words_sent > 300) begin
				// The receiver stalls for a long stretch during a large frame.
				held = 1'b1;
				calm = 1'b0;
				hold_request = 400;
				w = 12;
				h = 10;
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 10);
				calm = ($urandom_range(7) == 0);
			end
			run_frame(w, h, $urandom_range(2), 5);
		end
		calm = 1'b0;

		wait_idle();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- log_zero_crossing_edge_detect_top.f -----
rtl/lzc_pkg.sv
rtl/lzc_if.sv
rtl/lzc_ram.sv
rtl/lzc_ctrl.sv
rtl/lzc_conv.sv
rtl/lzc_zc.sv
rtl/log_zero_crossing_edge_detect_top.sv
bench/edge_checker.sv
bench/testbench.sv
